FILE: rtl/lldf_pkg.sv
// Shared types and constants for the line local difference filter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lldf_pkg;

    localparam int PIX_W   = 8;
    localparam int SPAN_W  = 6;
    localparam int GAIN_W  = 16;
    localparam int OFS_W   = 18;
    localparam int DIST_W  = 7;     // back distance into history, up to 2*63
    // ring address: a job reads up to 126 back while the front writes up to
    // four queued jobs of 64 pixels each ahead of it
    localparam int HIST_AW = 9;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_HALF_SPAN = 2'd0;
    localparam logic [1:0] REG_GAIN      = 2'd1;
    localparam logic [1:0] REG_OFFSET    = 2'd2;

    localparam logic [SPAN_W-1:0]        HALF_SPAN_RST = 6'd10;
    localparam logic signed [GAIN_W-1:0] GAIN_RST      = 16'sd256;
    localparam logic signed [OFS_W-1:0]  OFFSET_RST    = 18'sd32768;

    // history write from front to back
    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        logic [PIX_W-1:0]   data;
    } t_hist_wr;

    // one classified pixel: emit outputs for back distances b_start down to b_end
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [PIX_W-1:0]   first;
        logic [DIST_W-1:0]  pos_lo;   // line position, saturated at DIST_MAX
        logic [HIST_AW-1:0] slot;
        logic [DIST_W-1:0]  b_start;
        logic [DIST_W-1:0]  b_end;
        logic               last;
    } t_job;

endpackage
`default_nettype wire

FILE: rtl/lldf_in_if.sv
// Input pixel channel: valid/ready handshake with pixel and end-of-line mark.
// Depends on lldf_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
interface lldf_in_if;
    logic                        valid;
    logic                        ready;
    logic [lldf_pkg::PIX_W-1:0]  pixel_in;
    logic                        line_end_in;

    modport source (output valid, output pixel_in, output line_end_in, input ready);
    modport sink   (input valid, input pixel_in, input line_end_in, output ready);
endinterface
`default_nettype wire

FILE: rtl/lldf_out_if.sv
// Result channel: valid/ready handshake with filtered pixel and end-of-line mark.
// Depends on lldf_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
interface lldf_out_if;
    logic                        valid;
    logic                        ready;
    logic [lldf_pkg::PIX_W-1:0]  pixel_out;
    logic                        line_end_out;

    modport source (output valid, output pixel_out, output line_end_out, input ready);
    modport sink   (input valid, input pixel_out, input line_end_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/lldf_front.sv
// Front end: accepts pixels, tracks line position, writes history, builds jobs.
// Depends on lldf_pkg and lldf_in_if.
`timescale 1ns / 1ps
`default_nettype none
module lldf_front #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    lldf_in_if.sink                            i_pix,
    input  wire logic [lldf_pkg::SPAN_W-1:0]   i_half_span,
    input  wire logic                          i_q_ready,
    output      logic                          o_push,
    output      lldf_pkg::t_job                o_job,
    output      lldf_pkg::t_hist_wr            o_wr
);
    localparam int PW = $clog2(MAX_LINE_WIDTH);
    localparam int CW = (PW > lldf_pkg::DIST_W) ? PW : lldf_pkg::DIST_W;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_LINE_WIDTH - 1);

    logic [PW-1:0]                  r_pos, n_pos;
    logic [lldf_pkg::PIX_W-1:0]     r_first, n_first;
    logic [lldf_pkg::HIST_AW-1:0]   r_slot;

    logic                           accept;
    logic                           has_center;
    logic [lldf_pkg::DIST_W-1:0]    pos_lo;
    logic [lldf_pkg::DIST_W-1:0]    span7;
    logic [lldf_pkg::DIST_W-1:0]    b_start;

    assign i_pix.ready = i_q_ready;
    assign accept      = i_pix.valid & i_pix.ready;

    always_comb begin
        has_center = CW'(r_pos) >= CW'(i_half_span);
        pos_lo     = (CW'(r_pos) > CW'(lldf_pkg::DIST_MAX)) ? lldf_pkg::DIST_MAX
                                                             : lldf_pkg::DIST_W'(r_pos);
        span7      = lldf_pkg::DIST_W'(i_half_span);
        // with a center output the walk starts at 2L, otherwise at pos+L (pos < L here)
        b_start    = has_center ? {i_half_span, 1'b0} : pos_lo + span7;
        n_first    = (r_pos == '0) ? i_pix.pixel_in : r_first;

        o_job.pix     = i_pix.pixel_in;
        o_job.first   = n_first;
        o_job.pos_lo  = pos_lo;
        o_job.slot    = r_slot;
        o_job.b_start = b_start;
        o_job.b_end   = i_pix.line_end_in ? span7 : b_start;
        o_job.last    = i_pix.line_end_in;
        o_push        = accept & (has_center | i_pix.line_end_in);

        o_wr.en   = accept;
        o_wr.addr = r_slot;
        o_wr.data = i_pix.pixel_in;

        if (i_pix.line_end_in) begin
            n_pos = '0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + PW'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_first <= '0;
            r_slot  <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_first <= n_first;
            r_slot  <= r_slot + lldf_pkg::HIST_AW'(1);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lldf_queue.sv
// Short job queue between front and back end.
// Depends on lldf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lldf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lldf_pkg::t_job i_job,
    output      logic           o_ready,
    input  wire logic           i_pop,
    output      logic           o_valid,
    output      lldf_pkg::t_job o_job
);
    lldf_pkg::t_job                  r_mem [lldf_pkg::QUEUE_DEPTH];
    logic [lldf_pkg::QUEUE_AW-1:0]   r_wr, r_rd;
    logic [lldf_pkg::QUEUE_AW:0]     r_cnt;
    logic                            do_push, do_pop;

    assign o_ready = r_cnt != (lldf_pkg::QUEUE_AW + 1)'(lldf_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + lldf_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + lldf_pkg::QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (lldf_pkg::QUEUE_AW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (lldf_pkg::QUEUE_AW + 1)'(1);
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lldf_back.sv
// Back end: pixel history ring, output sequencer, scale pipeline, result register.
// Depends on lldf_pkg and lldf_out_if.
`timescale 1ns / 1ps
`default_nettype none
module lldf_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire lldf_pkg::t_hist_wr                   i_wr,
    input  wire logic                                 i_q_valid,
    input  wire lldf_pkg::t_job                       i_job,
    output      logic                                 o_pop,
    input  wire logic signed [lldf_pkg::GAIN_W-1:0]   i_gain,
    input  wire logic signed [lldf_pkg::OFS_W-1:0]    i_offset,
    lldf_out_if.source                                o_res
);
    localparam int PW    = lldf_pkg::PIX_W;
    localparam int PROD_W = PW + 1 + lldf_pkg::GAIN_W;
    localparam int SUM_W  = PROD_W + 1;

    typedef struct packed {
        logic          use_first;
        logic          use_cur;
        logic [PW-1:0] pix;
        logic [PW-1:0] first;
        logic          flag;
    } t_tap;

    logic [PW-1:0]                  r_hist [lldf_pkg::HIST_DEPTH];

    logic                           en;
    logic                           r_busy;
    lldf_pkg::t_job                 r_job;
    logic [lldf_pkg::DIST_W-1:0]    r_b;
    logic                           last_issue;
    logic [lldf_pkg::HIST_AW-1:0]   rd_addr;

    logic                           r1_v;
    logic [PW-1:0]                  r_rd;
    t_tap                           r1_tap;

    logic                           r2_v;
    logic                           r2_flag;
    logic signed [PROD_W-1:0]       r_prod;
    logic [PW-1:0]                  left;
    logic [PW-1:0]                  diff;

    logic signed [SUM_W-1:0]        sum;
    logic [PW-1:0]                  clamped;

    logic                           r_ov;
    logic [PW-1:0]                  r_opix;
    logic                           r_oend;

    // the whole pipeline holds while the result register is full and stalled
    assign en         = !r_ov || o_res.ready;
    assign last_issue = r_b == r_job.b_end;
    assign o_pop      = i_q_valid && (!r_busy || (en && last_issue));
    assign rd_addr    = r_job.slot - lldf_pkg::HIST_AW'(r_b);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_hist[i_wr.addr] <= i_wr.data;
        end
        if (en) begin
            r_rd <= r_hist[rd_addr];
        end
    end

    // sequencer: walk back distance from b_start down to b_end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (en && r_busy && last_issue) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_b   <= i_job.b_start;
        end else if (en && r_busy) begin
            r_b   <= r_b - lldf_pkg::DIST_W'(1);
        end
    end

    always_comb begin
        left = r1_tap.use_cur   ? r1_tap.pix :
               r1_tap.use_first ? r1_tap.first : r_rd;
        diff = (left > r1_tap.pix) ? left - r1_tap.pix : r1_tap.pix - left;
        sum  = SUM_W'(r_prod) + SUM_W'(i_offset);
        if (sum[SUM_W-1]) begin
            clamped = '0;
        end else if (|sum[SUM_W-2:2*PW]) begin
            clamped = '1;
        end else begin
            clamped = sum[2*PW-1:PW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= r_busy;
            r2_v <= r1_v;
            r_ov <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_tap.use_first <= r_b > r_job.pos_lo;
            r1_tap.use_cur   <= r_b == '0;
            r1_tap.pix       <= r_job.pix;
            r1_tap.first     <= r_job.first;
            r1_tap.flag      <= r_job.last & last_issue;
            r_prod           <= $signed({1'b0, diff}) * i_gain;
            r2_flag          <= r1_tap.flag;
            r_opix           <= clamped;
            r_oend           <= r2_flag;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.pixel_out    = r_opix;
    assign o_res.line_end_out = r_oend;
endmodule
`default_nettype wire

FILE: rtl/line_local_difference_filter_unit.sv
// Line local difference filter: |p[x-L] - p[x+L]| * gain + offset, clamped to 0..255.
// Top level; depends on lldf_pkg, lldf_in_if, lldf_out_if, lldf_front, lldf_queue, lldf_back.
//
// Usage:
//   i_pix carries one grey pixel per transfer with an end-of-line mark; o_res carries
//   one filtered pixel per transfer, its end-of-line mark set on the last result of a
//   line. half_span, gain (Q8.8) and offset (Q10.8) sit on the APB port at 0x0, 0x4,
//   0x8; write them only while the block is idle. pready is tied high.
//   Throughput: one result per cycle from the back-end sequencer while o_res is ready;
//   it issues one history read per cycle. A mid-line pixel releases one result; the
//   end-of-line pixel releases its whole flush run, and the front keeps taking pixels
//   until the four-entry job queue fills. Pixels with no result are handled at the front only.
//   Path: an input transfer reaches its first result through the queue, sequencer
//   load, history read, multiply and result register.
//   Reset clears the line position, ring pointer, first pixel, queue and pipeline
//   valids, and loads half_span 10, gain 1.0, offset 128.0. History needs no clear.
//   A stalled o_res holds the result register and freezes the back end; the queue
//   then fills and i_pix.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module line_local_difference_filter_unit #(
    parameter int MAX_HALF_SPAN  = 63,
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lldf_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [lldf_pkg::PDATA_W-1:0]      pwdata,
    output      logic [lldf_pkg::PDATA_W-1:0]      prdata,
    output      logic                              pready,
    lldf_in_if.sink                                i_pix,
    lldf_out_if.source                             o_res
);
    localparam logic [lldf_pkg::SPAN_W-1:0] SPAN_LIMIT = lldf_pkg::SPAN_W'(MAX_HALF_SPAN);

    // configuration registers
    logic [lldf_pkg::SPAN_W-1:0]        r_half_span;
    logic signed [lldf_pkg::GAIN_W-1:0] r_gain;
    logic signed [lldf_pkg::OFS_W-1:0]  r_offset;
    logic                               cfg_wr;
    logic [lldf_pkg::SPAN_W-1:0]        span_wdata;

    // front to queue to back
    logic               push, q_ready, q_valid, pop;
    lldf_pkg::t_job     push_job, q_job;
    lldf_pkg::t_hist_wr hist_wr;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite & pready;
    // clamp the span to what the history ring is sized for
    assign span_wdata = (pwdata[lldf_pkg::SPAN_W-1:0] > SPAN_LIMIT) ? SPAN_LIMIT
                                                                    : pwdata[lldf_pkg::SPAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_span <= lldf_pkg::HALF_SPAN_RST;
            r_gain      <= lldf_pkg::GAIN_RST;
            r_offset    <= lldf_pkg::OFFSET_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                lldf_pkg::REG_HALF_SPAN: r_half_span <= span_wdata;
                lldf_pkg::REG_GAIN:      r_gain      <= pwdata[lldf_pkg::GAIN_W-1:0];
                lldf_pkg::REG_OFFSET:    r_offset    <= pwdata[lldf_pkg::OFS_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            lldf_pkg::REG_HALF_SPAN: prdata = lldf_pkg::PDATA_W'(r_half_span);
            lldf_pkg::REG_GAIN:      prdata = lldf_pkg::PDATA_W'(r_gain);
            lldf_pkg::REG_OFFSET:    prdata = lldf_pkg::PDATA_W'(r_offset);
            default:                 prdata = '0;
        endcase
    end

    // front: position tracking, history write, job classification
    lldf_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_half_span (r_half_span),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_job       (push_job),
        .o_wr        (hist_wr)
    );

    // hold jobs so the front keeps taking pixels during a flush run
    lldf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // back: one history read and one result per cycle while o_res is ready
    lldf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (hist_wr),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .i_gain    (r_gain),
        .i_offset  (r_offset),
        .o_res     (o_res)
    );
endmodule
`default_nettype wire

FILE: tb/line_local_difference_filter_unit_tb.sv
// Self-checking testbench for the line local difference filter: directed and random pixel
// lines, APB settings changes while idle, random input gaps and random result stalls.
// Depends on lldf_pkg, lldf_in_if, lldf_out_if and line_local_difference_filter_unit.
`timescale 1ns / 1ps
module line_local_difference_filter_unit_tb;
    localparam int PIX_W   = lldf_pkg::PIX_W;
    localparam int SPAN_W  = lldf_pkg::SPAN_W;
    localparam int GAIN_W  = lldf_pkg::GAIN_W;
    localparam int OFS_W   = lldf_pkg::OFS_W;
    localparam int PADDR_W = lldf_pkg::PADDR_W;
    localparam int PDATA_W = lldf_pkg::PDATA_W;

    localparam logic [1:0] REG_HALF_SPAN = lldf_pkg::REG_HALF_SPAN;
    localparam logic [1:0] REG_GAIN      = lldf_pkg::REG_GAIN;
    localparam logic [1:0] REG_OFFSET    = lldf_pkg::REG_OFFSET;

    localparam int LINE_WIDTH_MAX = 4096;
    localparam int SPAN_MAX       = 63;
    localparam int RING_SIZE      = 128;       // pixel ring of the predictor
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 20;        // idle time before a register write
    localparam int TAIL_CYCLES    = 64;        // watch for stray results at the end
    localparam int RANDOM_PIXELS  = 500;
    localparam int MISMATCH_SHOWN = 10;
    // Slowest conceivable run: ~720 pixels each releasing 64 results, every result behind
    // the longest result stall; the limit lies well above that.
    localparam int CYCLE_LIMIT    = 20_000_000;

    // address 0xC lies beyond the register list and must be ignored
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // one filtered pixel as it leaves the block
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             eol;
    } t_filtered;

    // one directed transfer, optionally preceded by a full settings load
    typedef struct packed {
        logic                     cfg;
        logic [SPAN_W-1:0]        span;
        logic signed [GAIN_W-1:0] gain;
        logic signed [OFS_W-1:0]  ofs;
        logic [PIX_W-1:0]         pix;
        logic                     eol;
        logic                     has_exp;   // typed result below; its end mark equals eol
        logic [PIX_W-1:0]         exp_pix;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 23;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // reset settings (span 10, gain 1.0, offset 128.0): short line, all in the flush
        '{1'b0, 6'd0,  16'sd0,   18'sd0,     8'd0,   1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd0,  16'sd0,   18'sd0,     8'd255, 1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd0,  16'sd0,   18'sd0,     8'd7,   1'b1, 1'b0, 8'd0},
        // zero span: each pixel gives the offset alone, clamped
        '{1'b1, 6'd0,  16'h7FFF, 18'h20000,  8'd255, 1'b0, 1'b1, 8'd0},
        '{1'b0, 6'd0,  16'h7FFF, 18'h20000,  8'd0,   1'b1, 1'b1, 8'd0},
        '{1'b1, 6'd0,  16'h8000, 18'h1FFFF,  8'd128, 1'b0, 1'b1, 8'd255},
        '{1'b0, 6'd0,  16'h8000, 18'h1FFFF,  8'd1,   1'b1, 1'b1, 8'd255},
        '{1'b1, 6'd0,  16'sd0,   18'sd0,     8'd170, 1'b1, 1'b1, 8'd0},
        '{1'b1, 6'd0,  16'sd256, 18'sd32768, 8'd85,  1'b1, 1'b1, 8'd128},
        // widest span on a two-pixel line
        '{1'b1, 6'd63, 16'sd256, 18'sd0,     8'd255, 1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd63, 16'sd256, 18'sd0,     8'd0,   1'b1, 1'b0, 8'd0},
        // gain and offset at opposite extremes
        '{1'b1, 6'd1,  16'h8000, 18'h1FFFF,  8'd0,   1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd1,  16'h8000, 18'h1FFFF,  8'd255, 1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd1,  16'h8000, 18'h1FFFF,  8'd255, 1'b1, 1'b0, 8'd0},
        '{1'b1, 6'd1,  16'h7FFF, 18'h20000,  8'd0,   1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd1,  16'h7FFF, 18'h20000,  8'd1,   1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd1,  16'h7FFF, 18'h20000,  8'd255, 1'b1, 1'b0, 8'd0},
        // span raised from 2 to 4 in the middle of a line: a position repeats
        '{1'b1, 6'd2,  16'sd256, 18'sd32768, 8'd10,  1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd2,  16'sd256, 18'sd32768, 8'd20,  1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd2,  16'sd256, 18'sd32768, 8'd30,  1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd2,  16'sd256, 18'sd32768, 8'd40,  1'b0, 1'b0, 8'd0},
        '{1'b1, 6'd4,  16'sd256, 18'sd32768, 8'd50,  1'b0, 1'b0, 8'd0},
        '{1'b0, 6'd4,  16'sd256, 18'sd32768, 8'd60,  1'b1, 1'b0, 8'd0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    lldf_in_if  pix_if ();
    lldf_out_if res_if ();

    line_local_difference_filter_unit #(
        .MAX_HALF_SPAN  (SPAN_MAX),
        .MAX_LINE_WIDTH (LINE_WIDTH_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_if.sink),
        .o_res   (res_if.source)
    );

    // ---------------------------------------------------------------------------------
    // Predictor state: its own copy of the settings, the pixel ring and the line tracking
    // ---------------------------------------------------------------------------------
    logic [SPAN_W-1:0]        span_cfg   = lldf_pkg::HALF_SPAN_RST;
    logic signed [GAIN_W-1:0] gain_cfg   = lldf_pkg::GAIN_RST;
    logic signed [OFS_W-1:0]  offset_cfg = lldf_pkg::OFFSET_RST;
    logic [PIX_W-1:0]         history_ring [RING_SIZE];
    logic [6:0]               ring_wr    = '0;
    int                       line_pos   = 0;
    logic [PIX_W-1:0]         line_first = '0;

    t_filtered expected_q [$];   // filtered pixels still owed by the block
    int        fail_count   = 0;
    int        result_count = 0;
    int        cycle_count  = 0;

    initial begin
        for (int k = 0; k < RING_SIZE; k++)
            history_ring[k] = '0;
    end

    // |a - b| * gain + offset in Q.8, negative clamps to 0, truncate, saturate at 255
    function automatic logic [PIX_W-1:0] scale_contrast(logic [PIX_W-1:0] a,
                                                        logic [PIX_W-1:0] b);
        longint d;
        longint s;
        d = (a > b) ? longint'(a - b) : longint'(b - a);
        s = d * longint'(gain_cfg) + longint'(offset_cfg);
        if (s < 0)
            return '0;
        s = s / 256;
        if (s > 255)
            return 8'd255;
        return 8'(s);
    endfunction

    // pixel at line index idx; the pixel at index pos sits in ring slot slot
    function automatic logic [PIX_W-1:0] line_tap(int idx, int pos, logic [6:0] slot);
        logic [6:0] back;
        if (idx < 0)
            return line_first;
        back = 7'(pos - idx);
        return history_ring[7'(slot - back)];
    endfunction

    // Advance the predictor by one accepted pixel and queue the results it releases.
    function automatic void predict_pixel(logic [PIX_W-1:0] pix, logic eol);
        int         span;
        int         pos;
        int         start;
        logic [6:0] slot;
        span = int'(span_cfg);
        pos  = line_pos;
        slot = ring_wr;
        if (line_pos == 0)
            line_first = pix;
        history_ring[slot] = pix;
        ring_wr = slot + 7'd1;

        // centre x = pos - span is complete now; with span 0 it also closes the line
        if (pos >= span)
            expected_q.push_back({scale_contrast(line_tap(pos - 2 * span, pos, slot), pix),
                                  eol && (span == 0)});

        if (eol) begin
            // flush: remaining centres read the last pixel on their right side
            start = (pos - span + 1 < 0) ? 0 : pos - span + 1;
            for (int x = start; x <= pos; x++)
                expected_q.push_back({scale_contrast(line_tap(x - span, pos, slot), pix),
                                      x == pos});
            line_pos = 0;
        end else if (line_pos < LINE_WIDTH_MAX - 1) begin
            line_pos++;
        end
    endfunction

    // ---------------------------------------------------------------------------------
    // Clock and watchdog
    // ---------------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycle_count,
                 expected_q.size());
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ---------------------------------------------------------------------------------
    initial begin : result_stall
        int high_len;
        int low_len;
        forever begin
            case ($urandom_range(0, 9))
                0: begin            // long stretch without a stall
                    high_len = $urandom_range(200, 400);
                    low_len  = 0;
                end
                1: begin            // long stall: fill the job queue, hold the input
                    high_len = $urandom_range(1, 4);
                    low_len  = $urandom_range(20, 60);
                end
                default: begin
                    high_len = $urandom_range(1, 8);
                    low_len  = $urandom_range(0, 3);
                end
            endcase
            res_if.ready <= 1'b1;
            repeat (high_len) @(posedge i_clk);
            if (low_len > 0) begin
                res_if.ready <= 1'b0;
                repeat (low_len) @(posedge i_clk);
            end
        end
    end

    // Compare each result transfer with the oldest owed result, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MISMATCH_SHOWN)
                    $display("result %0d unexpected: pixel %0d end %0b", result_count,
                             res_if.pixel_out, res_if.line_end_out);
            end else begin
                if (res_if.pixel_out !== expected_q[0].pix ||
                    res_if.line_end_out !== expected_q[0].eol) begin
                    fail_count++;
                    if (fail_count <= MISMATCH_SHOWN)
                        $display("result %0d: expected pixel %0d end %0b, got pixel %0d end %0b",
                                 result_count, expected_q[0].pix, expected_q[0].eol,
                                 res_if.pixel_out, res_if.line_end_out);
                end
                void'(expected_q.pop_front());
            end
            result_count++;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------

    // Two-phase APB write; the register takes the value at the access edge.
    task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HALF_SPAN: span_cfg   = data[SPAN_W-1:0];
            REG_GAIN:      gain_cfg   = data[GAIN_W-1:0];
            REG_OFFSET:    offset_cfg = data[OFS_W-1:0];
            default: ;     // unmapped: ignored by the block
        endcase
        // keep the bus idle before returning so the next setup is a fresh assignment
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [SPAN_W-1:0] span,
                                 input logic [GAIN_W-1:0] gain,
                                 input logic [OFS_W-1:0]  ofs);
        apb_write(REG_HALF_SPAN, {{(PDATA_W - SPAN_W){1'b0}}, span});
        apb_write(REG_GAIN,      {{(PDATA_W - GAIN_W){gain[GAIN_W-1]}}, gain});
        apb_write(REG_OFFSET,    {{(PDATA_W - OFS_W){ofs[OFS_W-1]}}, ofs});
    endtask

    // Hold the input until every owed result has left, then let the pipe settle.
    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offer one pixel after an optional gap; valid stays high into the next transfer.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic eol, input int gap);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_in    <= pix;
        pix_if.line_end_in <= eol;
        do @(posedge i_clk); while (!pix_if.ready);
        predict_pixel(pix, eol);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SPAN_W-1:0] pick_span();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 6'(SPAN_MAX);
            2:       return 6'd1;
            3:       return 6'($urandom_range(2, 8));
            default: return 6'($urandom_range(0, SPAN_MAX));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return '0;
            3:       return 16'd256;
            4:       return 16'($urandom_range(0, 1023));
            5:       return -16'($urandom_range(1, 1023));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [OFS_W-1:0] pick_offset();
        case ($urandom_range(0, 7))
            0:       return 18'h20000;
            1:       return 18'h1FFFF;
            2:       return '0;
            3:       return 18'd32768;
            4:       return 18'($urandom_range(0, 65535));
            5:       return -18'($urandom_range(1, 65535));
            default: return 18'($urandom_range(0, 262143));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly short lines; some long enough for full flush runs, a few past the ring size.
    function automatic int pick_line_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(1, 24);
            6, 7, 8:          return int'(span_cfg) + $urandom_range(1, 70);
            default:          return $urandom_range(100, 200);
        endcase
    endfunction

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row step_row;
        int        random_sent;
        int        line_len;
        int        split_at;
        bit        burst;

        random_sent = 0;

        // drive every input to a known value from time zero
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel_in    <= '0;
        pix_if.line_end_in <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: walk the table; typed rows replace the predicted result
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            step_row = DIRECTED[n];
            if (step_row.cfg) begin
                wait_drained();
                load_settings(step_row.span, step_row.gain, step_row.ofs);
            end
            send_pixel(step_row.pix, step_row.eol, pick_gap());
            if (step_row.has_exp) begin
                void'(expected_q.pop_back());
                expected_q.push_back({step_row.exp_pix, step_row.eol});
            end
        end

        // a write beyond the register list must leave the settings alone
        wait_drained();
        apb_write(REG_UNMAPPED, $urandom());

        // Random part: whole lines with random content, settings changed between lines
        // and now and then the span changed in the middle of a line
        while (random_sent < RANDOM_PIXELS) begin
            if (random_sent == 0 || $urandom_range(0, 3) == 0) begin
                wait_drained();
                load_settings(pick_span(), pick_gain(), pick_offset());
            end
            line_len = pick_line_length();
            burst    = ($urandom_range(0, 2) == 0);
            split_at = (line_len > 4 && $urandom_range(0, 5) == 0) ?
                       $urandom_range(1, line_len - 1) : 0;
            for (int i = 0; i < line_len; i++) begin
                if (split_at != 0 && i == split_at) begin
                    wait_drained();
                    apb_write(REG_HALF_SPAN, {{(PDATA_W - SPAN_W){1'b0}}, pick_span()});
                end
                send_pixel(pick_pixel(), i == line_len - 1, burst ? 0 : pick_gap());
                random_sent++;
            end
        end

        // drain, then watch a while longer for stray results
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lldf_pkg.sv
rtl/lldf_in_if.sv
rtl/lldf_out_if.sv
rtl/lldf_front.sv
rtl/lldf_queue.sv
rtl/lldf_back.sv
rtl/line_local_difference_filter_unit.sv
tb/line_local_difference_filter_unit_tb.sv
